[rtl/ddo_pkg.sv]
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int ANG_W      = 32;
    localparam int DPP_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int RATE_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int VAL_W      = 64;
    localparam int CS_W       = 34;
    localparam int MB_W       = 34;
    localparam int MA_W       = 33;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int FULL_W     = PROD_W + 32;

    localparam logic signed [CS_W-1:0] CORDIC_K = CS_W'(652032874);

    localparam logic signed [DPP_W-1:0] LEFT_DPP_RST  = DPP_W'(2698587);
    localparam logic signed [DPP_W-1:0] RIGHT_DPP_RST = DPP_W'(2698587);
    localparam logic [GAIN_W-1:0]       GAIN_RST      = GAIN_W'(1367130551);
    localparam logic [RATE_W-1:0]       RATE_RST      = RATE_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_DPP     = 2'd0,
        CFG_RIGHT_DPP    = 2'd1,
        CFG_HEADING_GAIN = 2'd2,
        CFG_TICK_RATE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SH_0,
        SH_30,
        SH_32
    } t_shift;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_SAT
    } t_mul_ph;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_DL,
        OP_DR,
        OP_VL,
        OP_VR,
        OP_DTH,
        OP_TURN,
        OP_DX,
        OP_DY,
        OP_WVX,
        OP_WVY
    } t_op;

    typedef struct packed {
        logic   start;
        t_shift shift;
    } t_mul_req;

    function automatic logic [ANG_W-1:0] atan_q32(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0001;
            5'd31: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] add_sat64(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sub_sat64(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] mean2(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W-1:0] ha;
        logic signed [VAL_W-1:0] hb;
        logic signed [VAL_W-1:0] c;
        ha = a >>> 1;
        hb = b >>> 1;
        c  = $signed({{(VAL_W-1){1'b0}}, a[0] & b[0]});
        return ha + hb + c;
    endfunction

endpackage

[rtl/ddo_mul.sv]
module ddo_mul
    import ddo_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mul_req                i_req,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [MB_W-1:0]  i_b,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_result
);

    t_mul_ph                  r_ph;
    t_mul_ph                  n_ph;
    logic signed [VAL_W-1:0]  r_a;
    logic signed [MB_W-1:0]   r_b;
    t_shift                   r_sh;
    logic signed [PROD_W-1:0] r_lo;
    logic signed [FULL_W-1:0] r_full;

    logic signed [MA_W-1:0]   m_a;
    logic signed [PROD_W-1:0] prod;
    logic signed [FULL_W-1:0] n_full;
    logic signed [FULL_W-1:0] shifted;
    logic                     fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= MP_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            MP_IDLE: if (i_req.start) n_ph = MP_LO;
            MP_LO:   n_ph = MP_HI;
            MP_HI:   n_ph = MP_SAT;
            MP_SAT:  n_ph = MP_IDLE;
        endcase
    end

    always_comb begin
        if (r_ph == MP_LO) begin
            m_a = $signed({1'b0, r_a[31:0]});
        end else begin
            m_a = $signed({r_a[VAL_W-1], r_a[VAL_W-1:32]});
        end
        prod   = m_a * r_b;
        n_full = (FULL_W'(prod) <<< 32) + FULL_W'(r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == MP_IDLE && i_req.start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_sh <= i_req.shift;
        end
        if (r_ph == MP_LO) begin
            r_lo <= prod;
        end
        if (r_ph == MP_HI) begin
            r_full <= n_full;
        end
    end

    always_comb begin
        unique case (r_sh)
            SH_0:    shifted = r_full;
            SH_30:   shifted = r_full >>> 30;
            SH_32:   shifted = r_full >>> 32;
            default: shifted = r_full;
        endcase
        fits = (shifted[FULL_W-1:VAL_W-1] == {(FULL_W-VAL_W+1){shifted[VAL_W-1]}});
        if (fits) begin
            o_result = shifted[VAL_W-1:0];
        end else if (shifted[FULL_W-1]) begin
            o_result = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign o_done = (r_ph == MP_SAT);

endmodule

[rtl/ddo_cordic.sv]
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ANG_W-1:0]       i_angle,
    output logic                   o_valid,
    output logic signed [CS_W-1:0] o_cos,
    output logic signed [CS_W-1:0] o_sin
);

    localparam int IW = $clog2(CORDIC_STEPS);

    logic                   r_busy;
    logic                   r_valid;
    logic [IW-1:0]          r_i;
    logic                   r_flip;
    logic signed [CS_W-1:0] r_x;
    logic signed [CS_W-1:0] r_y;
    logic signed [CS_W-1:0] r_z;

    logic [ANG_W-1:0]       probe;
    logic                   fold;
    logic [ANG_W-1:0]       ang_f;
    logic signed [CS_W-1:0] atan_v;

    assign probe  = i_angle + 32'h4000_0000;
    assign fold   = probe[ANG_W-1];
    assign ang_f  = fold ? i_angle + 32'h8000_0000 : i_angle;
    assign atan_v = $signed({{(CS_W-ANG_W){1'b0}}, atan_q32(5'(r_i))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else if (r_busy && r_i == IW'(CORDIC_STEPS - 1)) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_flip <= fold;
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= CS_W'($signed(ang_f));
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (!r_z[CS_W-1]) begin
                r_x <= r_x - (r_y >>> r_i);
                r_y <= r_y + (r_x >>> r_i);
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + (r_y >>> r_i);
                r_y <= r_y - (r_x >>> r_i);
                r_z <= r_z + atan_v;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_cos   = r_flip ? -r_x : r_x;
    assign o_sin   = r_flip ? -r_y : r_y;

endmodule

[rtl/diff_drive_odometry_unit.sv]
// Each accepted tick runs ten products in turn through the one shared multiplier;
// the last four wait for the CORDIC cosine and sine of the pre-update heading.
// A new tick is taken only in the idle state, once the previous result has been
// loaded into the output registers, which an output stall can hold off.
// The first tick after reset only arms the block. Reset is synchronous, active
// low, and restores register defaults and clears pose and heading.
module diff_drive_odometry_unit
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COUNT_BITS-1:0] i_left_count,
    input  logic signed [COUNT_BITS-1:0] i_right_count,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [VAL_W-1:0]      o_pos_x,
    output logic signed [VAL_W-1:0]      o_pos_y,
    output logic [ANG_W-1:0]             o_heading_angle,
    output logic signed [VAL_W-1:0]      o_speed_left,
    output logic signed [VAL_W-1:0]      o_speed_right,
    output logic signed [VAL_W-1:0]      o_world_vx,
    output logic signed [VAL_W-1:0]      o_world_vy,
    output logic signed [VAL_W-1:0]      o_turn_rate
);

    t_state                      r_state;
    t_state                      n_state;
    t_op                         r_op;
    t_op                         n_op;
    logic                        r_armed;
    logic                        r_out_valid;

    logic signed [DPP_W-1:0]     r_ldpp;
    logic signed [DPP_W-1:0]     r_rdpp;
    logic [GAIN_W-1:0]           r_gain;
    logic [RATE_W-1:0]           r_rate;

    logic signed [COUNT_BITS-1:0] r_lc;
    logic signed [COUNT_BITS-1:0] r_rc;
    logic signed [VAL_W-1:0]     r_x;
    logic signed [VAL_W-1:0]     r_y;
    logic [ANG_W-1:0]            r_head;
    logic signed [VAL_W-1:0]     r_dl;
    logic signed [VAL_W-1:0]     r_dr;
    logic signed [VAL_W-1:0]     r_vl;
    logic signed [VAL_W-1:0]     r_vr;
    logic signed [VAL_W-1:0]     r_dth;
    logic signed [VAL_W-1:0]     r_turn;
    logic signed [VAL_W-1:0]     r_wvx;
    logic signed [VAL_W-1:0]     r_wvy;

    logic signed [VAL_W-1:0]     r_o_x;
    logic signed [VAL_W-1:0]     r_o_y;
    logic [ANG_W-1:0]            r_o_head;
    logic signed [VAL_W-1:0]     r_o_vl;
    logic signed [VAL_W-1:0]     r_o_vr;
    logic signed [VAL_W-1:0]     r_o_wvx;
    logic signed [VAL_W-1:0]     r_o_wvy;
    logic signed [VAL_W-1:0]     r_o_turn;

    logic                        in_accept;
    logic                        out_accept;
    logic                        out_load;
    logic                        need_cs;
    logic                        mul_start;
    t_mul_req                    mul_req;
    logic signed [VAL_W-1:0]     mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic                        mul_done;
    logic signed [VAL_W-1:0]     mul_res;
    logic                        cs_valid;
    logic signed [CS_W-1:0]      cs_cos;
    logic signed [CS_W-1:0]      cs_sin;
    logic signed [VAL_W-1:0]     dm;
    logic signed [VAL_W-1:0]     vm;
    logic signed [VAL_W-1:0]     diff;
    logic signed [MB_W-1:0]      rate_b;

    ddo_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept && r_armed),
        .i_angle (r_head),
        .o_valid (cs_valid),
        .o_cos   (cs_cos),
        .o_sin   (cs_sin)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_accept  = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    assign dm     = mean2(r_dl, r_dr);
    assign vm     = mean2(r_vl, r_vr);
    assign diff   = sub_sat64(r_dr, r_dl);
    assign rate_b = MB_W'(r_rate);
    assign need_cs = (r_op == OP_DX) || (r_op == OP_DY) || (r_op == OP_WVX) || (r_op == OP_WVY);

    always_comb begin
        mul_req.start = mul_start;
        mul_a = r_dl;
        mul_b = rate_b;
        mul_req.shift = SH_0;
        unique case (r_op)
            OP_DL: begin
                mul_a = VAL_W'(r_ldpp);
                mul_b = MB_W'(r_lc);
            end
            OP_DR: begin
                mul_a = VAL_W'(r_rdpp);
                mul_b = MB_W'(r_rc);
            end
            OP_VL: begin
                mul_a = r_dl;
                mul_b = rate_b;
            end
            OP_VR: begin
                mul_a = r_dr;
                mul_b = rate_b;
            end
            OP_DTH: begin
                mul_a = diff;
                mul_b = MB_W'(r_gain);
                mul_req.shift = SH_32;
            end
            OP_TURN: begin
                mul_a = r_dth;
                mul_b = rate_b;
            end
            OP_DX: begin
                mul_a = dm;
                mul_b = cs_cos;
                mul_req.shift = SH_30;
            end
            OP_DY: begin
                mul_a = dm;
                mul_b = cs_sin;
                mul_req.shift = SH_30;
            end
            OP_WVX: begin
                mul_a = vm;
                mul_b = cs_cos;
                mul_req.shift = SH_30;
            end
            OP_WVY: begin
                mul_a = vm;
                mul_b = cs_sin;
                mul_req.shift = SH_30;
            end
            default: begin
                mul_a = r_dl;
                mul_b = rate_b;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        mul_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && r_armed) begin
                    n_state = ST_ISSUE;
                    n_op    = OP_DL;
                end
            end
            ST_ISSUE: begin
                if (!need_cs || cs_valid) begin
                    mul_start = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mul_done) begin
                    if (r_op == OP_WVY) begin
                        n_state = ST_OUT;
                    end else begin
                        n_op    = t_op'(r_op + 4'd1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_DL;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
            r_ldpp      <= LEFT_DPP_RST;
            r_rdpp      <= RIGHT_DPP_RST;
            r_gain      <= GAIN_RST;
            r_rate      <= RATE_RST;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (in_accept) begin
                r_armed <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LEFT_DPP:     r_ldpp <= i_cfg_data;
                    CFG_RIGHT_DPP:    r_rdpp <= i_cfg_data;
                    CFG_HEADING_GAIN: r_gain <= i_cfg_data;
                    CFG_TICK_RATE:    r_rate <= i_cfg_data[RATE_W-1:0];
                endcase
            end
            if (r_state == ST_WAIT && mul_done) begin
                if (r_op == OP_DTH) begin
                    r_head <= r_head + mul_res[ANG_W-1:0];
                end
                if (r_op == OP_DX) begin
                    r_x <= add_sat64(r_x, mul_res);
                end
                if (r_op == OP_DY) begin
                    r_y <= add_sat64(r_y, mul_res);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_lc <= i_left_count;
            r_rc <= i_right_count;
        end
        if (r_state == ST_WAIT && mul_done) begin
            unique case (r_op)
                OP_DL:   r_dl   <= mul_res;
                OP_DR:   r_dr   <= mul_res;
                OP_VL:   r_vl   <= mul_res;
                OP_VR:   r_vr   <= mul_res;
                OP_DTH:  r_dth  <= mul_res;
                OP_TURN: r_turn <= mul_res;
                OP_WVX:  r_wvx  <= mul_res;
                OP_WVY:  r_wvy  <= mul_res;
                default: ;
            endcase
        end
        if (out_load) begin
            r_o_x    <= r_x;
            r_o_y    <= r_y;
            r_o_head <= r_head;
            r_o_vl   <= r_vl;
            r_o_vr   <= r_vr;
            r_o_wvx  <= r_wvx;
            r_o_wvy  <= r_wvy;
            r_o_turn <= r_turn;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_o_x;
    assign o_pos_y         = r_o_y;
    assign o_heading_angle = r_o_head;
    assign o_speed_left    = r_o_vl;
    assign o_speed_right   = r_o_vr;
    assign o_world_vx      = r_o_wvx;
    assign o_world_vy      = r_o_wvy;
    assign o_turn_rate     = r_o_turn;

endmodule

[verif/tb_diff_drive_odometry_unit.sv]
module tb_diff_drive_odometry_unit;
    import ddo_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int CW          = COUNT_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 64;
    localparam int IDLE_PCT    = 11;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 165;

    localparam logic signed [VAL_W-1:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic [ANG_W-1:0]        heading;
        logic signed [VAL_W-1:0] speed_l;
        logic signed [VAL_W-1:0] speed_r;
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
        logic signed [VAL_W-1:0] turn;
    } t_pose;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_valid   = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data    = '0;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_stall;
    logic signed [CW-1:0]         i_left_count  = '0;
    logic signed [CW-1:0]         i_right_count = '0;
    logic                         o_out_valid;
    logic                         i_out_stall   = 1'b0;
    logic signed [VAL_W-1:0]      o_pos_x;
    logic signed [VAL_W-1:0]      o_pos_y;
    logic [ANG_W-1:0]             o_heading_angle;
    logic signed [VAL_W-1:0]      o_speed_left;
    logic signed [VAL_W-1:0]      o_speed_right;
    logic signed [VAL_W-1:0]      o_world_vx;
    logic signed [VAL_W-1:0]      o_world_vy;
    logic signed [VAL_W-1:0]      o_turn_rate;

    logic signed [DPP_W-1:0] m_left_dpp  = 32'sd2698587;
    logic signed [DPP_W-1:0] m_right_dpp = 32'sd2698587;
    logic [GAIN_W-1:0]       m_gain      = 32'd1367130551;
    logic [RATE_W-1:0]       m_rate      = 10'd20;
    logic                    m_armed     = 1'b0;
    logic signed [VAL_W-1:0] m_x         = '0;
    logic signed [VAL_W-1:0] m_y         = '0;
    logic [ANG_W-1:0]        m_heading   = '0;

    logic [31:0] arc_tab [0:31] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    t_pose expected_poses [$];
    t_pose pose_due;
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    bit    calm           = 1'b0;

    diff_drive_odometry_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_left_count    (i_left_count),
        .i_right_count   (i_right_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading_angle (o_heading_angle),
        .o_speed_left    (o_speed_left),
        .o_speed_right   (o_speed_right),
        .o_world_vx      (o_world_vx),
        .o_world_vy      (o_world_vy),
        .o_turn_rate     (o_turn_rate)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [VAL_W-1:0] mul_shift_sat(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input int unsigned             sh
    );
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        wa = a;
        wb = b;
        p  = (wa * wb) >>> sh;
        if (p[127:63] == {65{p[127]}}) begin
            return p[63:0];
        end
        return p[127] ? S64_MIN : S64_MAX;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_add64(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? S64_MIN : S64_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_sub64(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? S64_MIN : S64_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] floor_mean(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        return s[VAL_W:1];
    endfunction

    function automatic void cordic_rotate(
        input  logic [ANG_W-1:0]        ang,
        output logic signed [VAL_W-1:0] c,
        output logic signed [VAL_W-1:0] s
    );
        logic [ANG_W-1:0]        a;
        logic [ANG_W-1:0]        q;
        logic                    flip;
        logic signed [VAL_W-1:0] cx;
        logic signed [VAL_W-1:0] cy;
        logic signed [VAL_W-1:0] cz;
        logic signed [VAL_W-1:0] nx;
        a    = ang;
        q    = a + 32'h4000_0000;
        flip = q[31];
        if (flip) begin
            a = a + 32'h8000_0000;
        end
        cx = 64'sd652032874;
        cy = '0;
        cz = {{32{a[31]}}, a};
        for (int i = 0; i < STEPS; i++) begin
            if (!cz[63]) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - {32'b0, arc_tab[i]};
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + {32'b0, arc_tab[i]};
            end
            cx = nx;
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endfunction

    function automatic void advance_odometry(
        input logic signed [CW-1:0] lc,
        input logic signed [CW-1:0] rc
    );
        logic signed [VAL_W-1:0] dl;
        logic signed [VAL_W-1:0] dr;
        logic signed [VAL_W-1:0] vl;
        logic signed [VAL_W-1:0] vr;
        logic signed [VAL_W-1:0] dm;
        logic signed [VAL_W-1:0] vm;
        logic signed [VAL_W-1:0] cs;
        logic signed [VAL_W-1:0] sn;
        logic signed [VAL_W-1:0] diff;
        logic signed [VAL_W-1:0] dth;
        logic signed [VAL_W-1:0] rate;
        logic [ANG_W-1:0]        old_h;
        t_pose                   p;
        if (!m_armed) begin
            m_armed = 1'b1;
            return;
        end
        rate  = {54'b0, m_rate};
        dl    = mul_shift_sat(m_left_dpp, lc, 0);
        dr    = mul_shift_sat(m_right_dpp, rc, 0);
        vl    = mul_shift_sat(dl, rate, 0);
        vr    = mul_shift_sat(dr, rate, 0);
        dm    = floor_mean(dl, dr);
        vm    = floor_mean(vl, vr);
        old_h = m_heading;
        cordic_rotate(old_h, cs, sn);
        diff  = sat_sub64(dr, dl);
        dth   = mul_shift_sat(diff, {32'b0, m_gain}, 32);
        m_x   = sat_add64(m_x, mul_shift_sat(dm, cs, 30));
        m_y   = sat_add64(m_y, mul_shift_sat(dm, sn, 30));
        m_heading = old_h + dth[31:0];
        p.pos_x   = m_x;
        p.pos_y   = m_y;
        p.heading = m_heading;
        p.speed_l = vl;
        p.speed_r = vr;
        p.vx      = mul_shift_sat(vm, cs, 30);
        p.vy      = mul_shift_sat(vm, sn, 30);
        p.turn    = mul_shift_sat(dth, rate, 0);
        expected_poses.push_back(p);
    endfunction

    task automatic check_field(input string tag, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            if (mismatch_count < 10) begin
                $display("%s mismatch at cycle %0d: expected %h, got %h",
                         tag, cycle_count, want, got);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("diff_drive_odometry_unit test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_poses.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result beat at cycle %0d", cycle_count);
                end
                mismatch_count++;
            end else begin
                pose_due = expected_poses.pop_front();
                check_field("pos_x", pose_due.pos_x, o_pos_x);
                check_field("pos_y", pose_due.pos_y, o_pos_y);
                check_field("heading_angle", {32'b0, pose_due.heading}, {32'b0, o_heading_angle});
                check_field("speed_left", pose_due.speed_l, o_speed_left);
                check_field("speed_right", pose_due.speed_r, o_speed_right);
                check_field("world_vx", pose_due.vx, o_world_vx);
                check_field("world_vy", pose_due.vy, o_world_vy);
                check_field("turn_rate", pose_due.turn, o_turn_rate);
            end
        end
        i_out_stall <= i_rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_tick(input logic signed [CW-1:0] l, input logic signed [CW-1:0] r);
        int gap;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(0, 99) < 3) begin
                gap = $urandom_range(1, 50);
            end
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                gap++;
            end
        end
        if (gap > 0) begin
            i_in_valid    <= 1'b0;
            i_left_count  <= CW'($urandom);
            i_right_count <= CW'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_count  <= l;
        i_right_count <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_odometry(l, r);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LEFT_DPP:     m_left_dpp  = data;
            CFG_RIGHT_DPP:    m_right_dpp = data;
            CFG_HEADING_GAIN: m_gain      = data;
            CFG_TICK_RATE:    m_rate      = data[RATE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(
        input logic [31:0] left_dpp,
        input logic [31:0] right_dpp,
        input logic [31:0] gain,
        input logic [31:0] rate_word
    );
        settle();
        write_reg(CFG_LEFT_DPP, left_dpp);
        write_reg(CFG_RIGHT_DPP, right_dpp);
        write_reg(CFG_HEADING_GAIN, gain);
        write_reg(CFG_TICK_RATE, rate_word);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_dpp();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom_range(1000000, 5000000);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'h0000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(100000000, 2000000000);
        endcase
    endfunction

    function automatic logic [31:0] pick_rate_word();
        logic [31:0] hi;
        hi = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FC00) : 32'h0;
        case ($urandom_range(0, 5))
            0:       return hi;
            1:       return hi | 32'd1;
            2:       return hi | 32'd1023;
            default: return hi | $urandom_range(1, 1000);
        endcase
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    task automatic random_tick();
        int mid;
        int l;
        int r;
        mid = int'($urandom_range(0, 600)) - 300;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                l = mid + int'($urandom_range(0, 40)) - 20;
                r = mid + int'($urandom_range(0, 40)) - 20;
            end
            11, 12, 13, 14, 15: begin
                l = $urandom;
                r = $urandom;
            end
            16, 17: begin
                l = pick_extreme();
                r = pick_extreme();
            end
            default: begin
                l = int'($urandom_range(0, 65535)) - 32768;
                r = -l;
            end
        endcase
        send_tick(CW'(l), CW'(r));
    endtask

    task automatic test_arming_and_defaults();
        // arming beat: counts are dropped
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(0, 0);
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(1, -1);
        send_tick(-1, -1);
        send_tick(16'sh5555, 16'shAAAA);
    endtask

    task automatic test_register_extremes();
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1023);
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(0, 16'sh8000);
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'd1);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(1, 1);
    endtask

    task automatic test_zero_rate();
        configure($urandom, $urandom, $urandom, 32'hFFFF_FC00);
        send_tick(16'sd1234, -16'sd4321);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(CW'($urandom), CW'($urandom));
    endtask

    task automatic test_random_drive();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                configure(32'd2698587, 32'd2698587, 32'd1367130551, 32'd20);
            end else begin
                configure(pick_dpp(), pick_dpp(), pick_gain(), pick_rate_word());
            end
            calm = (ph == 4);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                random_tick();
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arming_and_defaults();
        test_register_extremes();
        test_zero_rate();
        test_random_drive();
        settle();
        if (mismatch_count == 0) begin
            $display("diff_drive_odometry_unit test passed");
        end else begin
            $display("diff_drive_odometry_unit test failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ddo_pkg.sv
rtl/ddo_mul.sv
rtl/ddo_cordic.sv
rtl/diff_drive_odometry_unit.sv
verif/tb_diff_drive_odometry_unit.sv
